FILE: hw/rtl/dual_phase_hilbert_fir_defines.svh
// Assertion macros for the dual-phase Hilbert FIR.
// Taken in by the top level; expects signals named clk and rst_n in scope.
`ifndef DUAL_PHASE_HILBERT_FIR_DEFINES_SVH
`define DUAL_PHASE_HILBERT_FIR_DEFINES_SVH

// Property checked on every rising edge outside reset.
`define DPHF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define DPHF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/dphf_pkg.sv
// Shared constants and coefficient table for the dual-phase Hilbert FIR.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package dphf_pkg;

    localparam int TAPS      = 24;
    localparam int CLIENTS   = 8;
    localparam int ROM_SIZE  = 64;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int CLIENT_W  = $clog2(CLIENTS);
    localparam int TAP_W     = $clog2(TAPS);
    localparam int ROM_AW    = $clog2(ROM_SIZE);
    localparam int LINE_W    = CLIENT_W + 1;           // phase bit and client
    localparam int MEM_AW    = LINE_W + TAP_W;
    localparam int MEM_DEPTH = 1 << MEM_AW;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int ACC_W     = PROD_W + TAP_W + 3;
    localparam int FRAC_W    = 15;

    // Q1.15 coefficients; entries past the filter length read as zero.
    function automatic logic signed [COEF_W-1:0] coef_at(input logic [ROM_AW-1:0] k);
        logic signed [COEF_W-1:0] c;
        begin
            case (k)
                6'd0:    c = -16'sd85;
                6'd1:    c = -16'sd14;
                6'd2:    c = -16'sd398;
                6'd3:    c = 16'sd13;
                6'd4:    c = -16'sd552;
                6'd5:    c = -16'sd527;
                6'd6:    c = 16'sd433;
                6'd7:    c = -16'sd1809;
                6'd8:    c = 16'sd2517;
                6'd9:    c = -16'sd1240;
                6'd10:   c = 16'sd3663;
                6'd11:   c = 16'sd23029;
                6'd12:   c = 16'sd2177;
                6'd13:   c = -16'sd12606;
                6'd14:   c = -16'sd632;
                6'd15:   c = -16'sd3245;
                6'd16:   c = -16'sd2051;
                6'd17:   c = -16'sd256;
                6'd18:   c = -16'sd1464;
                6'd19:   c = 16'sd87;
                6'd20:   c = -16'sd401;
                6'd21:   c = -16'sd89;
                6'd22:   c = 16'sd33;
                6'd23:   c = -16'sd58;
                default: c = '0;
            endcase
            return c;
        end
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/dphf_in_if.sv
// Input channel of the dual-phase Hilbert FIR: sample, client and phase request.
// Depends on dphf_pkg for field widths.
`default_nettype none

interface dphf_in_if import dphf_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic [CLIENT_W-1:0]        client;
    logic                       func;

    modport source (output valid, output sample, output client, output func, input ready);
    modport sink   (input valid, input sample, input client, input func, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/dphf_out_if.sv
// Output channel of the dual-phase Hilbert FIR: one filtered sample per request.
// Depends on dphf_pkg for field widths.
`default_nettype none

interface dphf_out_if import dphf_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/dual_phase_hilbert_fir.sv
// Dual-phase Hilbert FIR top level: delay-line memory, shared MAC and sequencer.
// Depends on dphf_pkg, dphf_in_if, dphf_out_if and the assertion macro header.
//
// Usage:
//   audio is a valid/ready sink; each request carries a sample, a client number
//   and a phase (0 = +45 degree path, 1 = -45 degree path). filt is a
//   valid/ready source giving one rounded, saturated result per request.
//   The sample is stored in the client's line for that phase, then one shared
//   16x16 multiplier walks all 24 taps, one tap per cycle, from a single-port
//   read of the delay-line memory through a two-stage read/multiply pipeline.
//   Each product is added into the accumulator; once the pipeline has drained,
//   the rounded result is loaded into the output register. A new request is
//   taken only in idle, after the previous result has been loaded.
//   Reset: control state clears at once; then a clearing pass writes zero to
//   all 512 memory words, one a cycle, with audio.ready low until it ends.
//   Stall: a finished result sits in the output register; the next request is
//   taken and computed meanwhile, and its result waits in the sequencer until
//   the output register is free.
`default_nettype none
`include "dual_phase_hilbert_fir_defines.svh"

module dual_phase_hilbert_fir import dphf_pkg::*; (
    input  wire        clk,
    input  wire        rst_n,
    dphf_in_if.sink    audio,
    dphf_out_if.source filt
);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_MAC    = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    localparam logic [TAP_W-1:0]  TAP_LAST = TAP_W'(TAPS - 1);
    localparam logic [MEM_AW-1:0] CLR_LAST = '1;
    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1 << (FRAC_W - 1));
    localparam logic signed [ACC_W-FRAC_W-1:0] SAT_MAX = (ACC_W-FRAC_W)'(32767);
    localparam logic signed [ACC_W-FRAC_W-1:0] SAT_MIN = -(ACC_W-FRAC_W)'(32768);

    state_t state_reg, state_next;

    logic [MEM_AW-1:0] clr_reg, clr_next;
    logic [TAP_W-1:0]  wpos_reg [2*CLIENTS];
    logic [LINE_W-1:0] line_reg, line_next;
    logic [TAP_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [TAP_W-1:0]  iss_reg, iss_next;
    logic              iss_on_reg, iss_on_next;
    logic              v1_reg, v2_reg;
    logic signed [COEF_W-1:0] coef_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic              out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] out_data_reg;

    logic signed [SAMPLE_W-1:0] mem [MEM_DEPTH];
    logic signed [SAMPLE_W-1:0] mem_q;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr;
    logic signed [SAMPLE_W-1:0] mem_wdata;
    logic [MEM_AW-1:0] mem_raddr;

    logic              accept;
    logic              issue;
    logic              out_load;
    logic [LINE_W-1:0] in_line;
    logic [TAP_W-1:0]  wp_cur;
    logic [TAP_W-1:0]  wp_adv;
    logic [TAP_W-1:0]  coef_k;
    logic signed [ACC_W-1:0]        rounded;
    logic signed [ACC_W-FRAC_W-1:0] shifted;
    logic signed [SAMPLE_W-1:0]     saturated;

    // The client field is exactly CLIENT_W bits wide, so it needs no reduction.
    assign in_line = {audio.func, audio.client};
    assign wp_cur  = wpos_reg[in_line];
    assign wp_adv  = (wp_cur == TAP_LAST) ? '0 : wp_cur + 1'b1;

    assign audio.ready = (state_reg == ST_IDLE);
    assign accept      = audio.valid && audio.ready;
    assign issue       = (state_reg == ST_MAC) && iss_on_reg;

    // Forward phase reads the table in order, the other phase reversed.
    assign coef_k = line_reg[LINE_W-1] ? TAP_LAST - iss_reg : iss_reg;

    assign rounded   = acc_reg + ROUND_BIAS;
    assign shifted   = rounded[ACC_W-1:FRAC_W];
    assign saturated = (shifted > SAT_MAX) ? SAMPLE_W'(SAT_MAX)
                     : (shifted < SAT_MIN) ? SAMPLE_W'(SAT_MIN)
                     : shifted[SAMPLE_W-1:0];

    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || filt.ready);

    assign filt.valid    = out_valid_reg;
    assign filt.filtered = out_data_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = {in_line, wp_cur};
        mem_wdata = audio.sample;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end
        else if (accept)
        begin
            mem_we = 1'b1;
        end
    end

    assign mem_raddr = {line_reg, rd_ptr_reg};

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        line_next      = line_reg;
        rd_ptr_next    = rd_ptr_reg;
        iss_next       = iss_reg;
        iss_on_next    = iss_on_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && filt.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (v2_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    line_next   = in_line;
                    rd_ptr_next = wp_adv;      // oldest sample sits right after the new one
                    iss_next    = '0;
                    iss_on_next = 1'b1;
                    acc_next    = '0;
                    state_next  = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (iss_on_reg)
                begin
                    rd_ptr_next = (rd_ptr_reg == TAP_LAST) ? '0 : rd_ptr_reg + 1'b1;
                    iss_next    = iss_reg + 1'b1;
                    if (iss_reg == TAP_LAST)
                    begin
                        iss_on_next = 1'b0;
                    end
                end
                else if (!v1_reg && !v2_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            line_reg      <= '0;
            rd_ptr_reg    <= '0;
            iss_reg       <= '0;
            iss_on_reg    <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 2*CLIENTS; i++)
            begin
                wpos_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            line_reg      <= line_next;
            rd_ptr_reg    <= rd_ptr_next;
            iss_reg       <= iss_next;
            iss_on_reg    <= iss_on_next;
            v1_reg        <= issue;
            v2_reg        <= v1_reg;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                wpos_reg[in_line] <= wp_adv;
            end
        end
    end

    // Datapath registers: read data, coefficient, product, accumulator, output.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q    <= mem[mem_raddr];
        coef_reg <= coef_at(ROM_AW'(coef_k));
        prod_reg <= mem_q * coef_reg;
        acc_reg  <= acc_next;
        if (out_load)
        begin
            out_data_reg <= saturated;
        end
    end

    `DPHF_ASSERT(a_out_from_finish, $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH), "output valid rose without a finished computation")
    `DPHF_ASSERT(a_wpos_in_range, accept |-> (wp_cur <= TAP_LAST), "write position beyond the filter length")
    `DPHF_ASSERT(a_drained_at_finish, (state_reg == ST_FINISH) |-> (!v1_reg && !v2_reg && !iss_on_reg), "MAC pipeline not empty when the result is taken")
    `DPHF_ASSERT_ALWAYS(a_no_accept_in_clear, (state_reg == ST_CLEAR) |-> !accept, "request accepted during the clearing pass")

endmodule

`default_nettype wire
